### rtl/svnc_pkg.sv
`timescale 1ns / 1ps
package svnc_pkg;

    localparam int MAX_EXTRA_BYTES = 4;

    localparam logic [7:0]  SIGN_MASK = 8'd128;
    localparam logic [3:0]  NIBBLE_MASK = 4'd15;
    localparam logic [7:0]  BYTE_MASK = 8'd255;
    localparam logic [2:0]  COUNT_MAX = 3'd7;
    localparam logic [31:0] MAG_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } svnc_op_t;

    typedef struct packed {
        logic        is_enc;
        logic [2:0]  count;
        logic [39:0] bytes;
        logic [31:0] value;
        logic        value_valid;
        logic        error;
    } svnc_cmd_t;

endpackage

### rtl/svnc_req_if.sv
`timescale 1ns / 1ps
interface svnc_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] value_in;
    logic [7:0]  byte_in;

    modport source (output valid, output opcode, output value_in, output byte_in, input ready);
    modport sink (input valid, input opcode, input value_in, input byte_in, output ready);
endinterface

### rtl/svnc_rsp_if.sv
`timescale 1ns / 1ps
interface svnc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic [31:0] value_out;
    logic        value_valid;
    logic        decode_error;
    logic        last;

    modport source (output valid, output byte_out, output byte_valid, output value_out,
                    output value_valid, output decode_error, output last, input ready);
    modport sink (input valid, input byte_out, input byte_valid, input value_out,
                  input value_valid, input decode_error, input last, output ready);
endinterface

### rtl/svnc_front.sv
`timescale 1ns / 1ps
module svnc_front (
    input  logic               clk,
    input  logic               rst_n,
    svnc_req_if.sink           req,
    output logic               push_valid,
    input  logic               push_ready,
    output svnc_pkg::svnc_cmd_t push_cmd
);
    import svnc_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  pos_reg, pos_next;
    logic        neg_reg, neg_next;
    logic [35:0] acc_reg, acc_next;

    logic        accept;
    logic        is_dec;
    logic        enc_neg;
    logic [31:0] enc_mag_raw;
    logic [31:0] enc_mag;
    logic [27:0] enc_rest;
    logic [2:0]  enc_count;
    logic [7:0]  enc_header;
    logic [5:0]  shamt;
    logic [35:0] acc_or;
    logic [2:0]  hdr_cnt;
    logic        dec_done;
    logic        dec_err;
    logic        dec_finish;
    logic [31:0] dec_value;

    assign accept = req.valid && push_ready;
    assign req.ready = push_ready;
    assign is_dec = (req.opcode == OP_DECODE);

    always_comb
    begin
        enc_neg = req.value_in[31];
        enc_mag_raw = enc_neg ? (32'd0 - req.value_in) : req.value_in;
        enc_mag = (enc_mag_raw > MAG_LIMIT) ? MAG_LIMIT : enc_mag_raw;
        enc_rest = enc_mag[31:4];
        if (enc_rest[27:24] != 4'd0)
        begin
            enc_count = 3'd4;
        end
        else if (enc_rest[23:16] != 8'd0)
        begin
            enc_count = 3'd3;
        end
        else if (enc_rest[15:8] != 8'd0)
        begin
            enc_count = 3'd2;
        end
        else if (enc_rest[7:0] != 8'd0)
        begin
            enc_count = 3'd1;
        end
        else
        begin
            enc_count = 3'd0;
        end
        enc_header = (enc_neg ? SIGN_MASK : 8'd0) | {1'b0, enc_count, 4'd0}
                     | {4'd0, enc_mag[3:0] & NIBBLE_MASK};
    end

    always_comb
    begin
        busy_next = busy_reg;
        rem_next = rem_reg;
        pos_next = pos_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        dec_done = 1'b0;
        dec_err = 1'b0;
        dec_finish = 1'b0;
        hdr_cnt = req.byte_in[6:4];
        shamt = 6'd4 + {1'b0, pos_reg[1:0], 3'd0};
        acc_or = acc_reg | ({28'd0, req.byte_in & BYTE_MASK} << shamt);
        if (!busy_reg)
        begin
            neg_next = (req.byte_in & SIGN_MASK) != 8'd0;
            acc_next = {32'd0, req.byte_in[3:0]};
            pos_next = 3'd0;
            if (hdr_cnt > 3'(MAX_EXTRA_BYTES))
            begin
                rem_next = 3'd0;
                dec_done = 1'b1;
                dec_err = 1'b1;
            end
            else if (hdr_cnt == 3'd0)
            begin
                dec_finish = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                rem_next = hdr_cnt;
            end
        end
        else
        begin
            acc_next = acc_or;
            pos_next = (pos_reg + 3'd1) & COUNT_MAX;
            rem_next = (rem_reg - 3'd1) & COUNT_MAX;
            if (rem_next == 3'd0 || pos_next >= 3'(MAX_EXTRA_BYTES))
            begin
                dec_finish = 1'b1;
            end
        end
        if (dec_finish)
        begin
            busy_next = 1'b0;
            rem_next = 3'd0;
            pos_next = 3'd0;
            dec_done = 1'b1;
            dec_err = acc_next[35:31] != 5'd0;
        end
        dec_value = neg_next ? (32'd0 - acc_next[31:0]) : acc_next[31:0];
    end

    always_comb
    begin
        push_valid = req.valid && (!is_dec || dec_done);
        push_cmd.is_enc = !is_dec;
        push_cmd.count = is_dec ? 3'd0 : enc_count;
        push_cmd.bytes = {4'd0, enc_rest, enc_header};
        push_cmd.value = (is_dec && !dec_err) ? dec_value : 32'd0;
        push_cmd.value_valid = is_dec && !dec_err;
        push_cmd.error = is_dec && dec_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg <= 3'd0;
            pos_reg <= 3'd0;
            neg_reg <= 1'b0;
            acc_reg <= 36'd0;
        end
        else if (accept && is_dec)
        begin
            busy_reg <= busy_next;
            rem_reg <= rem_next;
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            acc_reg <= acc_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg != 3'd0))
        else $error("decoder busy with no bytes remaining");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg + pos_reg) <= 4'(MAX_EXTRA_BYTES))
        else $error("decoder byte accounting exceeds limit");
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (rem_reg == 3'd0 && pos_reg == 3'd0))
        else $error("idle decoder holds stale counters");
`endif
endmodule

### rtl/svnc_queue.sv
`timescale 1ns / 1ps
module svnc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  svnc_pkg::svnc_cmd_t push_cmd,
    output logic                pop_valid,
    input  logic                pop_ready,
    output svnc_pkg::svnc_cmd_t pop_cmd
);
    import svnc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    svnc_cmd_t      mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign push_ready = cnt_reg != CW'(DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count overflow");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
    a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count lost a pop");
`endif
endmodule

### rtl/svnc_back.sv
`timescale 1ns / 1ps
module svnc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  svnc_pkg::svnc_cmd_t pop_cmd,
    svnc_rsp_if.source          rsp
);
    import svnc_pkg::*;

    svnc_cmd_t   cmd_reg;
    logic        active_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        bvalid_reg;
    logic [31:0] value_reg;
    logic        vvalid_reg;
    logic        err_reg;
    logic        last_reg;
    logic        load;
    logic        at_end;
    logic [7:0]  sel_byte;

    assign pop_ready = !active_reg;
    assign load = active_reg && (!out_valid_reg || rsp.ready);
    assign at_end = idx_reg == cmd_reg.count;

    always_comb
    begin
        case (idx_reg)
            3'd0: sel_byte = cmd_reg.bytes[7:0];
            3'd1: sel_byte = cmd_reg.bytes[15:8];
            3'd2: sel_byte = cmd_reg.bytes[23:16];
            3'd3: sel_byte = cmd_reg.bytes[31:24];
            3'd4: sel_byte = cmd_reg.bytes[39:32];
            default: sel_byte = 8'd0;
        endcase
        out_valid_next = load ? 1'b1 : (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            cmd_reg <= pop_cmd;
        end
        if (load)
        begin
            byte_reg <= cmd_reg.is_enc ? sel_byte : 8'd0;
            bvalid_reg <= cmd_reg.is_enc;
            value_reg <= cmd_reg.is_enc ? 32'd0 : cmd_reg.value;
            vvalid_reg <= !cmd_reg.is_enc && cmd_reg.value_valid;
            err_reg <= !cmd_reg.is_enc && cmd_reg.error;
            last_reg <= at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop_valid && pop_ready)
            begin
                active_reg <= 1'b1;
                idx_reg <= 3'd0;
            end
            else if (load)
            begin
                if (at_end)
                begin
                    active_reg <= 1'b0;
                    idx_reg <= 3'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.byte_out = byte_reg;
    assign rsp.byte_valid = bvalid_reg;
    assign rsp.value_out = value_reg;
    assign rsp.value_valid = vvalid_reg;
    assign rsp.decode_error = err_reg;
    assign rsp.last = last_reg;

`ifndef SYNTHESIS
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg <= cmd_reg.count))
        else $error("result index past command length");
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bvalid_reg |-> (!vvalid_reg && !err_reg))
        else $error("encode result carries decode status");
    a_dec_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !bvalid_reg |-> (last_reg && (vvalid_reg != err_reg)))
        else $error("malformed decode result");
`endif
endmodule

### rtl/signed_varint_nibble_codec.sv
`timescale 1ns / 1ps
// Signed varint codec with a nibble header byte.
// Channel req carries one transaction per item: opcode selects encode of
// value_in or decode of one byte_in. Channel rsp carries result transactions
// in item order, last marking the final result of each item.
// An encode yields 1 to 5 byte results, header first. A decode yields no
// result while extra bytes are still expected, else one value or error result.
// The front stage accepts a transaction while the queue has room and posts its
// work to a command queue of QUEUE_DEPTH entries; the back stage drains one
// command at a time and loads one result per cycle into the output register
// while rsp is not stalled. A command is written into the queue, popped into
// the back stage's command register, and its results are then loaded into the
// output register. The back stage takes no new command until the last result
// of its current one is loaded. Decode bytes that yield no result post no
// command. Reset clears the decoder state, the queue pointers and count, and
// the output valid flag. When rsp stalls, the output register holds; the
// queue fills and req.ready drops once QUEUE_DEPTH commands are waiting.
module signed_varint_nibble_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    svnc_req_if.sink   req,
    svnc_rsp_if.source rsp
);
    import svnc_pkg::*;

    logic      push_valid, push_ready;
    svnc_cmd_t push_cmd;
    logic      pop_valid, pop_ready;
    svnc_cmd_t pop_cmd;

    svnc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    svnc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    svnc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );
endmodule
